/* hdl/dbpa_pkg.sv */
package dbpa_pkg;

  localparam int AMT_W    = 32;
  localparam int LANES    = 4;
  localparam int CFG_W    = 13;
  localparam int OUT_SLOT_W = 12;

  localparam logic [1:0] OP_ACC_NEXT = 2'd0;
  localparam logic [1:0] OP_ACC_CUR  = 2'd1;
  localparam logic [1:0] OP_SWAP     = 2'd2;
  localparam logic [1:0] OP_LOOKUP   = 2'd3;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_HIT      = 3'd3;
  localparam logic [2:0] ST_MISS     = 3'd4;
  localparam logic [2:0] ST_SWAPPED  = 3'd5;

  localparam logic [CFG_W-1:0] SLOT_LIMIT_RST = 13'd4096;

  typedef struct packed {
    logic [1:0]       operation;
    logic [9:0]       site;
    logic [3:0]       direction;
    logic [AMT_W-1:0] photons_f0;
    logic [AMT_W-1:0] photons_f1;
    logic [AMT_W-1:0] photons_f2;
    logic [AMT_W-1:0] photons_f3;
  } in_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [AMT_W-1:0]      sum_f0;
    logic [AMT_W-1:0]      sum_f1;
    logic [AMT_W-1:0]      sum_f2;
    logic [AMT_W-1:0]      sum_f3;
    logic                  saturated;
  } out_t;

endpackage

/* hdl/dbpa_map_ram.sv */
module dbpa_map_ram #(
  parameter int AW = 15,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/dbpa_store.sv */
module dbpa_store #(
  parameter int KEY_W    = 14,
  parameter int SLOT_W   = 12,
  parameter int NUM_FREQ = 4
) (
  input  logic                                   clk,
  input  logic                                   rd_en,
  input  logic [SLOT_W:0]                        rd_addr,
  output logic [KEY_W-1:0]                       rd_key,
  output logic [NUM_FREQ-1:0][dbpa_pkg::AMT_W-1:0] rd_sums,
  input  logic                                   merge,
  input  logic [NUM_FREQ-1:0][dbpa_pkg::AMT_W-1:0] add_lanes,
  output logic [NUM_FREQ-1:0][dbpa_pkg::AMT_W-1:0] upd_sums,
  output logic                                   upd_sat,
  input  logic                                   wr_en,
  input  logic [SLOT_W:0]                        wr_addr,
  input  logic [KEY_W-1:0]                       wr_key
);

  localparam int DW = KEY_W + NUM_FREQ * dbpa_pkg::AMT_W;

  logic [DW-1:0] mem [2**(SLOT_W+1)];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_key, upd_sums};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_key  = rd_data_r[DW-1 -: KEY_W];
  assign rd_sums = rd_data_r[NUM_FREQ*dbpa_pkg::AMT_W-1:0];

  // existing slot: per-lane saturating add, new slot: plain assign
  always_comb begin
    logic [dbpa_pkg::AMT_W:0] s;
    upd_sat  = 1'b0;
    upd_sums = add_lanes;
    for (int f = 0; f < NUM_FREQ; f++) begin
      s = {1'b0, rd_sums[f]} + {1'b0, add_lanes[f]};
      if (merge) begin
        if (s[dbpa_pkg::AMT_W]) begin
          upd_sums[f] = '1;
          upd_sat     = 1'b1;
        end else begin
          upd_sums[f] = s[dbpa_pkg::AMT_W-1:0];
        end
      end
    end
  end

endmodule

/* hdl/double_buffered_packet_accumulator_core.sv */
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_data (dbpa_pkg::in_t)
// out     | output    | out_valid/out_stall | out_data (dbpa_pkg::out_t)
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (slot_limit, 13 bits)
//
// a request runs through key map read, packet store read, then update and write-back
// into the packet store, and into the key map for a new slot; one request is in flight at a time
// the result sits in an output register, so the next request is taken while it waits
// out_stall only holds the final step when the output register is still full
// reset is synchronous; no clearing pass: a map entry counts only if its slot is
// below the bank's fill count and the store entry at that slot carries the same key
module double_buffered_packet_accumulator_core #(
  parameter int NUM_SITES = 1024,
  parameter int NUM_DIR   = 16,
  parameter int NUM_FREQ  = 4,
  parameter int NUM_SLOTS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dbpa_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dbpa_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbpa_pkg::CFG_W-1:0]    cfg_data
);

  localparam int KEY_W  = (NUM_SITES * NUM_DIR > 1) ? $clog2(NUM_SITES * NUM_DIR) : 1;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int LIM_W  = (CNT_W > dbpa_pkg::CFG_W) ? CNT_W : dbpa_pkg::CFG_W;
  localparam int AW_    = dbpa_pkg::AMT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MAP, ST_STORE} state_t;

  state_t                    state_r, state_nxt;
  dbpa_pkg::in_t             req_r, req_nxt;
  logic [KEY_W-1:0]          key_r, key_nxt;
  logic                      range_r, range_nxt;
  logic                      bank_r, bank_nxt;
  logic                      bank_sel_r, bank_sel_nxt;
  logic [CNT_W-1:0]          cnt_r [2];
  logic [CNT_W-1:0]          cnt_nxt [2];
  logic [dbpa_pkg::CFG_W-1:0] limit_r, limit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dbpa_pkg::out_t            out_data_r, out_data_nxt;

  logic                      accept;
  logic [31:0]               key_full;
  logic [KEY_W-1:0]          in_key;
  logic                      in_range;
  logic                      in_bank;

  logic [SLOT_W-1:0]         map_slot;
  logic                      map_rd_en, map_wr_en;
  logic [KEY_W-1:0]          st_key;
  logic [NUM_FREQ-1:0][AW_-1:0] st_sums, upd_sums, ph_lanes, res_sums;
  logic [dbpa_pkg::LANES-1:0][AW_-1:0] req_all, out_lanes;
  logic                      upd_sat;
  logic                      st_rd_en, st_wr_en;
  logic [SLOT_W-1:0]         new_slot;
  logic [SLOT_W-1:0]         wr_slot;
  logic                      hit, full, is_acc;
  logic                      finish;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign key_full = 32'(in_data.site) * 32'(NUM_DIR) + 32'(in_data.direction);
  assign in_key   = key_full[KEY_W-1:0];
  assign in_range = (32'(in_data.site) < 32'(NUM_SITES)) &&
                    (32'(in_data.direction) < 32'(NUM_DIR));
  assign in_bank  = (in_data.operation == dbpa_pkg::OP_ACC_NEXT) ? ~bank_sel_r : bank_sel_r;

  assign map_rd_en = accept;
  assign st_rd_en  = (state_r == ST_MAP);
  assign is_acc    = (req_r.operation == dbpa_pkg::OP_ACC_NEXT) ||
                     (req_r.operation == dbpa_pkg::OP_ACC_CUR);
  assign finish    = (state_r == ST_STORE) && (!out_valid_r || !out_stall);
  assign new_slot  = cnt_r[bank_r][SLOT_W-1:0];

  assign req_all = {req_r.photons_f3, req_r.photons_f2, req_r.photons_f1, req_r.photons_f0};

  always_comb begin
    for (int f = 0; f < NUM_FREQ; f++) begin
      ph_lanes[f] = req_all[f];
    end
  end

  // an unwritten map entry may hold anything; only a slot below the fill count
  // whose store entry carries the same key is a hit
  always_comb begin
    if ((CNT_W'(map_slot) < cnt_r[bank_r]) && (st_key == key_r)) begin
      hit = 1'b1;
    end else begin
      hit = 1'b0;
    end
  end

  assign full = (LIM_W'(cnt_r[bank_r]) >= LIM_W'(limit_r)) ||
                (cnt_r[bank_r] == CNT_W'(NUM_SLOTS));

  assign wr_slot   = hit ? map_slot : new_slot;
  assign st_wr_en  = finish && is_acc && range_r && (hit || !full);
  assign map_wr_en = finish && is_acc && range_r && !hit && !full;

  dbpa_map_ram #(
    .AW (KEY_W + 1),
    .DW (SLOT_W)
  ) u_map (
    .clk     (clk),
    .rd_en   (map_rd_en),
    .rd_addr ({in_bank, in_key}),
    .rd_data (map_slot),
    .wr_en   (map_wr_en),
    .wr_addr ({bank_r, key_r}),
    .wr_data (new_slot)
  );

  dbpa_store #(
    .KEY_W    (KEY_W),
    .SLOT_W   (SLOT_W),
    .NUM_FREQ (NUM_FREQ)
  ) u_store (
    .clk       (clk),
    .rd_en     (st_rd_en),
    .rd_addr   ({bank_r, map_slot}),
    .rd_key    (st_key),
    .rd_sums   (st_sums),
    .merge     (hit),
    .add_lanes (ph_lanes),
    .upd_sums  (upd_sums),
    .upd_sat   (upd_sat),
    .wr_en     (st_wr_en),
    .wr_addr   ({bank_r, wr_slot}),
    .wr_key    (key_r)
  );

  for (genvar f = 0; f < dbpa_pkg::LANES; f++) begin : g_lane
    if (f < NUM_FREQ) begin : g_used
      assign out_lanes[f] = res_sums[f];
    end else begin : g_unused
      assign out_lanes[f] = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    range_nxt     = range_r;
    bank_nxt      = bank_r;
    bank_sel_nxt  = bank_sel_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_sums      = '0;

    if (cfg_valid && cfg_ready) begin
      limit_nxt = cfg_data;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    out_data_nxt.status    = dbpa_pkg::ST_DROPPED;
    out_data_nxt.slot      = '0;
    out_data_nxt.saturated = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = in_data;
          key_nxt   = in_key;
          range_nxt = in_range;
          bank_nxt  = in_bank;
          state_nxt = ST_MAP;
        end
      end
      ST_MAP: begin
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        case (req_r.operation)
          dbpa_pkg::OP_SWAP: begin
            out_data_nxt.status = dbpa_pkg::ST_SWAPPED;
          end
          dbpa_pkg::OP_LOOKUP: begin
            if (range_r && hit) begin
              out_data_nxt.status = dbpa_pkg::ST_HIT;
              out_data_nxt.slot   = dbpa_pkg::OUT_SLOT_W'(map_slot);
              res_sums            = st_sums;
            end else begin
              out_data_nxt.status = dbpa_pkg::ST_MISS;
            end
          end
          default: begin
            if (!range_r) begin
              out_data_nxt.status = dbpa_pkg::ST_DROPPED;
            end else if (hit) begin
              out_data_nxt.status    = dbpa_pkg::ST_ADDED;
              out_data_nxt.slot      = dbpa_pkg::OUT_SLOT_W'(map_slot);
              out_data_nxt.saturated = upd_sat;
              res_sums               = upd_sums;
            end else if (!full) begin
              out_data_nxt.status = dbpa_pkg::ST_NEW;
              out_data_nxt.slot   = dbpa_pkg::OUT_SLOT_W'(new_slot);
              res_sums            = ph_lanes;
            end
          end
        endcase
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (req_r.operation == dbpa_pkg::OP_SWAP) begin
            // old current bank becomes next and empties
            cnt_nxt[bank_sel_r] = '0;
            bank_sel_nxt        = ~bank_sel_r;
          end
          if (map_wr_en) begin
            cnt_nxt[bank_r] = cnt_r[bank_r] + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt.sum_f0 = out_lanes[0];
    out_data_nxt.sum_f1 = out_lanes[1];
    out_data_nxt.sum_f2 = out_lanes[2];
    out_data_nxt.sum_f3 = out_lanes[3];
    if (!finish) begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bank_sel_r  <= 1'b0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      limit_r     <= dbpa_pkg::SLOT_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_sel_r  <= bank_sel_nxt;
      cnt_r       <= cnt_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    range_r    <= range_nxt;
    bank_r     <= bank_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
